@@ src/uart_frame_receiver_multi_slot_defines.svh @@
// Assertion macros shared by the frame receiver modules.
// Each module that asserts includes this header; clk and rst_n must be in scope.
`ifndef UART_FRAME_RECEIVER_MULTI_SLOT_DEFINES_SVH
`define UART_FRAME_RECEIVER_MULTI_SLOT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UFR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define UFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ufr_pkg.sv @@
// Shared constants, types and helpers of the frame receiver.
// No dependencies; every module imports this package.
`timescale 1ns / 1ps

package ufr_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int NUM_SLOTS   = 3;
    // Power of two, so the queue pointers wrap on their own.
    localparam int QUEUE_DEPTH = 4;

    localparam int CNT_W      = $clog2(FRAME_LEN);
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W  = 2;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDR = 2'd1;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    // One queued request: a single buffer write, or the start/address pair.
    typedef struct packed {
        logic       two_writes;
        logic [1:0] slot;
        logic [3:0] position;
        logic [7:0] value;
        logic [7:0] start_value;
        logic       frame_done;
        logic [1:0] pending;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    function automatic logic [3:0] to_position(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+3:0] wide;
        wide = {4'b0000, cnt};
        return wide[3:0];
    endfunction

    function automatic logic [1:0] to_slot(input logic [SLOT_IDX_W-1:0] idx);
        logic [SLOT_IDX_W+1:0] wide;
        wide = {2'b00, idx};
        return wide[1:0];
    endfunction

endpackage

@@ src/uart_frame_receiver_multi_slot.sv @@
// Frame receiver with several slots: front end, request queue, write sequencer.
// Depends on ufr_pkg, ufr_front, ufr_queue and ufr_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted cycle:
//   a received byte or a release of all pending frames. Output channel
//   (out_valid / out_stall) carries buffer writes: slot, position, value,
//   frame_done, pending_frames and last on the final write of an item.
//   Registers start_byte (index 0) and station_address (index 1) are written
//   through cfg_write / cfg_index / cfg_data; the user must write them only
//   while the block is idle; the block does not enforce it. Writes pass the
//   request queue and the registered output stage. Throughput: one item per
//   cycle unless in_stall. An address byte yields the start-byte and address
//   writes, a data byte one; releases and writeless bytes skip the sequencer.
//   A four-entry request queue absorbs bursts; in_stall rises when it is full.
//   Reset empties the queue and output stage, clears both registers to zero,
//   and restores the framing state (slot 0, pending count one).
//   While out_stall is high the output holds, the queue fills, then the input
//   stalls.
`timescale 1ns / 1ps

module uart_frame_receiver_multi_slot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    rx_byte,
    input  logic                          consumer_busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    slot,
    output logic [3:0]                    position,
    output logic [7:0]                    value,
    output logic                          frame_done,
    output logic [1:0]                    pending_frames,
    output logic                          last,
    input  logic                          cfg_write,
    input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import ufr_pkg::*;

    q_status_t status;
    entry_t    push_entry;
    entry_t    head;
    logic      push;
    logic      pop;

    ufr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .consumer_busy (consumer_busy),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .push          (push),
        .push_entry    (push_entry)
    );

    ufr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .status     (status),
        .head       (head)
    );

    ufr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .status         (status),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot           (slot),
        .position       (position),
        .value          (value),
        .frame_done     (frame_done),
        .pending_frames (pending_frames),
        .last           (last)
    );

endmodule

@@ src/ufr_front.sv @@
// Front end: accepts input items, tracks framing state, issues write requests.
// Depends on ufr_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "uart_frame_receiver_multi_slot_defines.svh"

module ufr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    rx_byte,
    input  logic                          consumer_busy,
    input  logic                          cfg_write,
    input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  ufr_pkg::q_status_t            status,
    output logic                          push,
    output ufr_pkg::entry_t               push_entry
);
    import ufr_pkg::*;

    logic [7:0]            start_byte_reg;
    logic [7:0]            station_addr_reg;
    logic                  start_seen_reg, start_seen_next;
    logic                  receiving_reg, receiving_next;
    logic [CNT_W-1:0]      wp_reg, wp_next;
    logic [SLOT_IDX_W-1:0] slot_reg, slot_next;
    logic                  ready_reg, ready_next;
    logic [1:0]            frame_count_reg, frame_count_next;

    logic                  accept;
    logic                  is_start;
    logic                  is_addr;
    logic [SLOT_IDX_W:0]   slot_plus;
    logic                  can_advance;
    logic [CNT_W:0]        pos_plus;
    logic                  at_end;

    assign in_stall    = status.full;
    assign accept      = in_valid && !status.full;
    assign is_start    = !receiving_reg && (rx_byte == start_byte_reg);
    assign is_addr     = !receiving_reg && !is_start && start_seen_reg
                         && (rx_byte == station_addr_reg);
    assign slot_plus   = {1'b0, slot_reg} + 1'b1;
    assign can_advance = slot_plus < (SLOT_IDX_W + 1)'(NUM_SLOTS);
    assign pos_plus    = {1'b0, wp_reg} + 1'b1;
    assign at_end      = pos_plus == (CNT_W + 1)'(FRAME_LEN);

    always_comb
    begin
        start_seen_next  = start_seen_reg;
        receiving_next   = receiving_reg;
        wp_next          = wp_reg;
        slot_next        = slot_reg;
        ready_next       = ready_reg;
        frame_count_next = frame_count_reg;
        push             = 1'b0;
        push_entry.two_writes = 1'b0;
        push_entry.position   = to_position(wp_reg);
        push_entry.frame_done = 1'b0;
        if (accept)
        begin
            if (operation == OP_RELEASE)
            begin
                ready_next       = 1'b0;
                frame_count_next = 2'd1;
            end
            else
            begin
                start_seen_next = is_start;
                if (is_addr)
                begin
                    receiving_next = 1'b1;
                    if ((ready_reg || consumer_busy) && can_advance)
                    begin
                        slot_next = slot_plus[SLOT_IDX_W-1:0];
                        if (frame_count_reg != COUNT_MAX)
                        begin
                            frame_count_next = frame_count_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        slot_next = '0;
                    end
                    // Address byte lands at position 1, the next byte at 2.
                    wp_next               = CNT_W'(2);
                    push                  = 1'b1;
                    push_entry.two_writes = 1'b1;
                    push_entry.position   = to_position(CNT_W'(1));
                end
                else if (receiving_reg)
                begin
                    push                  = 1'b1;
                    push_entry.frame_done = at_end;
                    if (at_end)
                    begin
                        receiving_next = 1'b0;
                        wp_next        = CNT_W'(1);
                        ready_next     = 1'b1;
                    end
                    else
                    begin
                        wp_next = pos_plus[CNT_W-1:0];
                    end
                end
            end
        end
        push_entry.slot        = to_slot(slot_next);
        push_entry.value       = rx_byte;
        push_entry.start_value = start_byte_reg;
        push_entry.pending     = frame_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= '0;
            station_addr_reg <= '0;
            start_seen_reg   <= 1'b0;
            receiving_reg    <= 1'b0;
            wp_reg           <= CNT_W'(1);
            slot_reg         <= '0;
            ready_reg        <= 1'b0;
            frame_count_reg  <= 2'd1;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_START_BYTE))
            begin
                start_byte_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == CFG_STATION_ADDR))
            begin
                station_addr_reg <= cfg_data;
            end
            start_seen_reg  <= start_seen_next;
            receiving_reg   <= receiving_next;
            wp_reg          <= wp_next;
            slot_reg        <= slot_next;
            ready_reg       <= ready_next;
            frame_count_reg <= frame_count_next;
        end
    end

    `UFR_ASSERT_IMPLIES(a_recv_not_armed, receiving_reg, !start_seen_reg,
        "start armed during reception")
    `UFR_ASSERT_IMPLIES(a_count_nonzero, 1'b1, frame_count_reg != 2'd0,
        "pending count dropped to zero")

endmodule

@@ src/ufr_queue.sv @@
// Short request queue between the front end and the write sequencer.
// Depends on ufr_pkg and the shared assertion header.
`timescale 1ns / 1ps
`include "uart_frame_receiver_multi_slot_defines.svh"

module ufr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ufr_pkg::entry_t    push_entry,
    input  logic               pop,
    output ufr_pkg::q_status_t status,
    output ufr_pkg::entry_t    head
);
    import ufr_pkg::*;

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign status.full      = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign status.not_empty = count_reg != '0;
    assign head             = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `UFR_ASSERT_IMPLIES(a_no_push_full, push, !status.full, "push into full queue")
    `UFR_ASSERT_IMPLIES(a_no_pop_empty, pop, status.not_empty, "pop from empty queue")

endmodule

@@ src/ufr_back.sv @@
// Write sequencer: expands queued requests into buffer writes, one per cycle if
// not stalled, behind a registered output. Depends on ufr_pkg, assertion header.
`timescale 1ns / 1ps
`include "uart_frame_receiver_multi_slot_defines.svh"

module ufr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ufr_pkg::q_status_t status,
    input  ufr_pkg::entry_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         slot,
    output logic [3:0]         position,
    output logic [7:0]         value,
    output logic               frame_done,
    output logic [1:0]         pending_frames,
    output logic               last
);
    import ufr_pkg::*;

    logic       out_valid_reg;
    logic       phase_reg, phase_next;
    logic [1:0] slot_reg;
    logic [3:0] position_reg, position_next;
    logic [7:0] value_reg, value_next;
    logic       done_reg, done_next;
    logic [1:0] pending_reg;
    logic       last_reg, last_next;
    logic       load;
    logic       take;
    logic       first_half;

    assign load       = !out_valid_reg || !out_stall;
    assign take       = load && status.not_empty;
    assign first_half = head.two_writes && !phase_reg;
    // Hold the entry after the start-byte write; drop it with its final write.
    assign pop        = take && !first_half;
    assign phase_next = take ? first_half : phase_reg;

    always_comb
    begin
        if (first_half)
        begin
            position_next = 4'd0;
            value_next    = head.start_value;
            done_next     = 1'b0;
            last_next     = 1'b0;
        end
        else
        begin
            position_next = head.position;
            value_next    = head.value;
            done_next     = head.frame_done;
            last_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= status.not_empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg     <= head.slot;
            position_reg <= position_next;
            value_reg    <= value_next;
            done_reg     <= done_next;
            pending_reg  <= head.pending;
            last_reg     <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot           = slot_reg;
    assign position       = position_reg;
    assign value          = value_reg;
    assign frame_done     = done_reg;
    assign pending_frames = pending_reg;
    assign last           = last_reg;

    `UFR_ASSERT_IMPLIES(a_phase_head, phase_reg, status.not_empty && head.two_writes,
        "second half pending without a paired request")
    `UFR_ASSERT_NEXT(a_pair_last, take && phase_reg, out_valid_reg && last_reg,
        "second write of a pair not marked last")

endmodule

@@ tb/ufr_buffer_write_monitor.sv @@
// Monitor for the multi-slot frame receiver: watches both channels and the register port.
// Predicts the buffer writes of every accepted request and compares them in order.
// Depends on ufr_pkg.
`timescale 1ns / 1ps

module ufr_buffer_write_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    rx_byte,
    input  logic                          consumer_busy,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    slot,
    input  logic [3:0]                    position,
    input  logic [7:0]                    value,
    input  logic                          frame_done,
    input  logic [1:0]                    pending_frames,
    input  logic                          last,
    input  logic                          cfg_write,
    input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output int                            mismatches,
    output int                            writes_outstanding
);
    import ufr_pkg::*;

    typedef struct packed {
        logic [1:0] slot;
        logic [3:0] position;
        logic [7:0] value;
        logic       frame_done;
        logic [1:0] pending;
        logic       last;
    } buffer_write_t;

    buffer_write_t awaited_writes [$];

    logic [7:0] start_value;
    logic [7:0] address_value;
    logic       armed;
    logic       receiving;
    logic       frame_ready_q;
    logic [7:0] next_position;
    logic [1:0] active_slot;
    logic [1:0] frame_count_q;

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic predict_buffer_writes(input logic op, input logic [7:0] b,
                                         input logic busy);
        buffer_write_t writes [2];
        int            n;
        logic [7:0]    pos;
        logic          done;
        n = 0;
        if (op == OP_RELEASE)
        begin
            // leave reception, slot and the armed start byte alone
            frame_ready_q = 1'b0;
            frame_count_q = 2'd1;
        end
        else
        begin
            if (!receiving && b == start_value)
            begin
                armed = 1'b1;
            end
            else if (!receiving && armed && b == address_value)
            begin
                receiving = 1'b1;
                armed     = 1'b0;
                if ((frame_ready_q || busy) && (int'(active_slot) + 1 < NUM_SLOTS))
                begin
                    active_slot = active_slot + 2'd1;
                    if (frame_count_q < COUNT_MAX)
                        frame_count_q = frame_count_q + 2'd1;
                end
                else
                begin
                    active_slot = 2'd0;
                end
                next_position = 8'd1;
                writes[n] = '{slot: active_slot, position: 4'd0, value: start_value,
                              frame_done: 1'b0, pending: 2'd0, last: 1'b0};
                n++;
            end
            else
            begin
                armed = 1'b0;
            end

            if (receiving)
            begin
                pos           = next_position;
                next_position = next_position + 8'd1;
                done          = (int'(next_position) == FRAME_LEN);
                if (done)
                begin
                    receiving     = 1'b0;
                    next_position = 8'd1;
                    armed         = 1'b0;
                    frame_ready_q = 1'b1;
                end
                writes[n] = '{slot: active_slot, position: pos[3:0], value: b,
                              frame_done: done, pending: 2'd0, last: 1'b0};
                n++;
            end

            for (int k = 0; k < n; k++)
            begin
                writes[k].pending = frame_count_q;
                writes[k].last    = (k == n - 1);
                awaited_writes.push_back(writes[k]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        buffer_write_t oldest;
        if (!rst_n)
        begin
            awaited_writes.delete();
            start_value        = 8'd0;
            address_value      = 8'd0;
            armed              = 1'b0;
            receiving          = 1'b0;
            frame_ready_q      = 1'b0;
            next_position      = 8'd1;
            active_slot        = 2'd0;
            frame_count_q      = 2'd1;
            mismatches         = 0;
            writes_outstanding = 0;
        end
        else
        begin
            // results leave only after their request has been queued, so compare first
            if (out_valid && !out_stall)
            begin
                if (awaited_writes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected write, expected none, %s %0d pos %0d value %0h",
                             $time, "actual slot", slot, position, value);
                end
                else
                begin
                    oldest = awaited_writes.pop_front();
                    check_field("slot", 8'(oldest.slot), 8'(slot));
                    check_field("position", 8'(oldest.position), 8'(position));
                    check_field("value", oldest.value, value);
                    check_field("frame_done", 8'(oldest.frame_done), 8'(frame_done));
                    check_field("pending_frames", 8'(oldest.pending), 8'(pending_frames));
                    check_field("last", 8'(oldest.last), 8'(last));
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_START_BYTE:   start_value   = cfg_data;
                    CFG_STATION_ADDR: address_value = cfg_data;
                    default:          ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_buffer_writes(operation, rx_byte, consumer_busy);

            writes_outstanding = awaited_writes.size();
        end
    end

endmodule

@@ tb/uart_frame_receiver_multi_slot_tb.sv @@
// Top of the frame receiver testbench: clock, reset, register writes and request stimulus.
// Depends on ufr_pkg, uart_frame_receiver_multi_slot and ufr_buffer_write_monitor.
`timescale 1ns / 1ps

module uart_frame_receiver_multi_slot_tb;
    import ufr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DATA_BYTES = FRAME_LEN - 2;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [7:0]           rx_byte;
    logic                 consumer_busy;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           slot;
    logic [3:0]           position;
    logic [7:0]           value;
    logic                 frame_done;
    logic [1:0]           pending_frames;
    logic                 last;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int         mismatches;
    int         writes_outstanding;
    int         cycles = 0;
    int         items_sent = 0;
    int         burst_left = 1;
    int         hold_requests = 0;
    logic       bursty = 1'b1;
    logic [7:0] cfg_start = 8'd0;
    logic [7:0] cfg_addr = 8'd0;

    uart_frame_receiver_multi_slot i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .consumer_busy  (consumer_busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot           (slot),
        .position       (position),
        .value          (value),
        .frame_done     (frame_done),
        .pending_frames (pending_frames),
        .last           (last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ufr_buffer_write_monitor i_monitor (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .operation          (operation),
        .rx_byte            (rx_byte),
        .consumer_busy      (consumer_busy),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .slot               (slot),
        .position           (position),
        .value              (value),
        .frame_done         (frame_done),
        .pending_frames     (pending_frames),
        .last               (last),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .writes_outstanding (writes_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("uart_frame_receiver_multi_slot verification failed");
            $finish;
        end
    end

    // Receiver side: stall pattern steps through four modes; long hold on request.
    initial
    begin : write_sink
        int cyc;
        int holds_done;
        cyc        = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (holds_done != hold_requests)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                case ((cyc / 512) % 4)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ((cyc % 11) < 4);
                endcase
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return cfg_start;
            1:       return cfg_addr;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one request and hold it until accepted; drop valid between bursts.
    task automatic send_item(input logic op, input logic [7:0] b, input logic busy);
        in_valid      <= 1'b1;
        operation     <= op;
        rx_byte       <= b;
        consumer_busy <= busy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (bursty)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic send_frame(input int n_data, input logic busy);
        send_item(OP_BYTE, cfg_start, 1'($urandom_range(0, 1)));
        send_item(OP_BYTE, cfg_addr, busy);
        for (int k = 0; k < n_data; k++)
            send_item(OP_BYTE, pick_byte(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_release();
        send_item(OP_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int n_items);
        int         target;
        int         kind;
        logic [7:0] b;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                send_frame(DATA_BYTES, 1'($urandom_range(0, 1)));
            end
            else if (kind < 65)
            begin
                send_frame($urandom_range(0, DATA_BYTES - 1), 1'($urandom_range(0, 1)));
            end
            else if (kind < 75)
            begin
                send_release();
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(OP_BYTE, pick_byte(), 1'($urandom_range(0, 1)));
            end
            else if (kind < 95)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        b = pick_byte();
                        if (b == cfg_addr)
                            b = b ^ 8'h01;
                        send_item(OP_BYTE, cfg_start, 1'b0);
                        send_item(OP_BYTE, b, 1'b1);
                    end
                    1:
                    begin
                        send_item(OP_BYTE, cfg_start, 1'b0);
                        send_frame($urandom_range(0, DATA_BYTES), 1'($urandom_range(0, 1)));
                    end
                    2:
                    begin
                        send_item(OP_BYTE, cfg_addr, 1'b1);
                    end
                    default:
                    begin
                        // a release between start and address keeps the start armed
                        send_item(OP_BYTE, cfg_start, 1'b0);
                        send_release();
                        send_item(OP_BYTE, cfg_addr, 1'($urandom_range(0, 1)));
                    end
                endcase
            end
            else
            begin
                send_frame(DATA_BYTES, 1'b1);
            end
        end
    endtask

    // Drain every expected write with the input idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (writes_outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] start_b, input logic [7:0] addr_b);
        cfg_start = start_b;
        cfg_addr  = addr_b;
        cfg_write <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data  <= start_b;
        @(posedge clk);
        cfg_index <= CFG_STATION_ADDR;
        cfg_data  <= addr_b;
        @(posedge clk);
        // indices past the register list must be ignored
        cfg_index <= CFG_SPARE_2;
        cfg_data  <= ~addr_b;
        @(posedge clk);
        cfg_index <= CFG_SPARE_3;
        cfg_data  <= ~start_b;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        operation     <= OP_BYTE;
        rx_byte       <= 8'h00;
        consumer_busy <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= CFG_START_BYTE;
        cfg_data      <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset registers: start and address both zero, so nothing can open
        run_random(40);
        settle();

        configure(8'hA5, 8'h3C);
        bursty = 1'b0;
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b1);
        send_item(OP_RELEASE, 8'hFF, 1'b1);
        send_item(OP_BYTE, 8'hA5, 1'b0);
        send_item(OP_BYTE, 8'h00, 1'b0);
        send_item(OP_BYTE, 8'hA5, 1'b0);
        send_item(OP_BYTE, 8'hA5, 1'b0);
        send_item(OP_BYTE, 8'h3C, 1'b0);
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            case (k)
                0:       send_item(OP_BYTE, 8'hFF, 1'b1);
                1:       send_item(OP_BYTE, 8'h00, 1'b0);
                2:       send_item(OP_BYTE, 8'hA5, 1'b0);
                3:       send_item(OP_BYTE, 8'h3C, 1'b1);
                default: send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            endcase
        end
        // frame still waiting: advance to the next slot
        send_item(OP_BYTE, 8'hA5, 1'b0);
        send_item(OP_BYTE, 8'h3C, 1'b0);
        send_item(OP_RELEASE, 8'h00, 1'b0);
        bursty = 1'b1;
        run_random(230);
        settle();

        configure(8'h00, 8'hFF);
        run_random(200);
        settle();

        configure(8'hFF, 8'h00);
        bursty = 1'b0;
        hold_requests++;
        run_random(200);
        settle();

        configure(8'h55, 8'h55);
        bursty = 1'b1;
        run_random(60);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            bursty = (p != 1);
            if (p == 1)
                hold_requests++;
            run_random(180);
            settle();
        end

        configure(8'h7E, 8'h01);
        bursty = 1'b1;
        run_random(150);
        settle();

        if (mismatches == 0 && writes_outstanding == 0)
            $display("uart_frame_receiver_multi_slot verification clean");
        else
            $display("uart_frame_receiver_multi_slot verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/ufr_pkg.sv
src/ufr_front.sv
src/ufr_queue.sv
src/ufr_back.sv
src/uart_frame_receiver_multi_slot.sv
tb/ufr_buffer_write_monitor.sv
tb/uart_frame_receiver_multi_slot_tb.sv
